// ----- sv/tcc_pkg.sv -----
// shared types, constants and helper functions for the tilt-compensated compass
`default_nettype none
package tcc_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int TABLE_LEN        = 24;

  localparam int ACC_W   = 14;
  localparam int FLD_W   = 16;
  localparam int M_W     = 18;
  localparam int S_W     = 30;
  localparam int ANG_W   = 16;
  localparam int Z_W     = 27;
  localparam int CW      = 54;
  localparam int TRIG_W  = 33;
  localparam int NUM_W   = 52;
  localparam int GAIN_W  = 16;
  localparam int MA_W    = 35;
  localparam int MB_W    = 34;
  localparam int MP_W    = MA_W + MB_W;
  localparam int RT_W    = 60;

  localparam logic [GAIN_W-1:0]       GAIN_RST    = 16'd13107;
  localparam logic signed [CW-1:0]    START_GAIN  = 54'sd652032874;
  localparam longint                  ACC_HI      = 64'sd8191 * 64'sd65536;
  localparam longint                  ACC_LO      = -64'sd8192 * 64'sd65536;
  localparam int                      ANGLE_LIMIT = 23040;
  localparam logic signed [Z_W-1:0]   QUARTER     = 27'sd5898240;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_CAL   = 2'd1,
    KIND_MEAS  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [M_W-1:0]   m_t;

  typedef struct packed {
    acc_t ax;
    acc_t ay;
    acc_t az;
    m_t   mx;
    m_t   my;
    m_t   mz;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILT_MUL,
    ST_FILT_ACC,
    ST_SQ1,
    ST_SQ2,
    ST_ROOT,
    ST_VLOAD,
    ST_VEC,
    ST_RLOAD,
    ST_ROT,
    ST_PROD,
    ST_OUT
  } state_t;

  // atan(2^-i) in degrees q.16
  function automatic logic signed [Z_W-1:0] atan_q16(input logic [4:0] i);
    logic signed [Z_W-1:0] v;
    case (i)
      5'd0:    v = 27'sd2949120;
      5'd1:    v = 27'sd1740967;
      5'd2:    v = 27'sd919879;
      5'd3:    v = 27'sd466945;
      5'd4:    v = 27'sd234379;
      5'd5:    v = 27'sd117304;
      5'd6:    v = 27'sd58666;
      5'd7:    v = 27'sd29335;
      5'd8:    v = 27'sd14668;
      5'd9:    v = 27'sd7334;
      5'd10:   v = 27'sd3667;
      5'd11:   v = 27'sd1833;
      5'd12:   v = 27'sd917;
      5'd13:   v = 27'sd458;
      5'd14:   v = 27'sd229;
      5'd15:   v = 27'sd115;
      5'd16:   v = 27'sd57;
      5'd17:   v = 27'sd29;
      5'd18:   v = 27'sd14;
      5'd19:   v = 27'sd7;
      5'd20:   v = 27'sd4;
      5'd21:   v = 27'sd2;
      5'd22:   v = 27'sd1;
      default: v = 27'sd0;
    endcase
    return v;
  endfunction

  // degrees q.16 to 1/128 degree, rounded and clamped
  function automatic logic signed [ANG_W-1:0] out_angle(input logic signed [Z_W-1:0] z);
    logic signed [Z_W:0] a;
    logic signed [ANG_W-1:0] r;
    a = (Z_W+1)'(z) + (Z_W+1)'(256);
    a = a >>> 9;
    if (a > (Z_W+1)'(ANGLE_LIMIT)) begin
      r = ANG_W'(ANGLE_LIMIT);
    end else if (a < -(Z_W+1)'(ANGLE_LIMIT)) begin
      r = -ANG_W'(ANGLE_LIMIT);
    end else begin
      r = ANG_W'(a);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- sv/tcc_front.sv -----
// front end: accepts words, keeps hard-iron calibration, queues measurements
`default_nettype none
module tcc_front import tcc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [95:0] in_tdata,  // accel_x, accel_y, accel_z, field_x, field_y, field_z
  input  wire logic [1:0]  in_tuser,  // kind
  output logic             q_push,
  output item_t            q_data,
  input  wire logic        q_full
);

  logic signed [FLD_W-1:0] fmin_r [3];
  logic signed [FLD_W-1:0] fmax_r [3];
  logic signed [FLD_W-1:0] fmin_nxt [3];
  logic signed [FLD_W-1:0] fmax_nxt [3];
  logic signed [FLD_W-1:0] fld [3];
  m_t                      m [3];
  kind_t                   kind;
  logic                    acc_ok;

  assign kind      = kind_t'(in_tuser);
  assign in_tready = !q_full;
  assign acc_ok    = in_tvalid && in_tready;

  assign fld[0] = $signed(in_tdata[57:42]);
  assign fld[1] = $signed(in_tdata[73:58]);
  assign fld[2] = $signed(in_tdata[89:74]);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fmin_nxt[i] = fmin_r[i];
      fmax_nxt[i] = fmax_r[i];
      m[i] = M_W'($signed({fld[i], 1'b0})) - (M_W'(fmax_r[i]) + M_W'(fmin_r[i]));
      if (acc_ok) begin
        case (kind)
          KIND_START: begin
            fmin_nxt[i] = fld[i];
            fmax_nxt[i] = fld[i];
          end
          KIND_CAL: begin
            if (fld[i] > fmax_r[i]) fmax_nxt[i] = fld[i];
            if (fld[i] < fmin_r[i]) fmin_nxt[i] = fld[i];
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign q_push    = acc_ok && (kind == KIND_MEAS);
  assign q_data.ax = $signed(in_tdata[13:0]);
  assign q_data.ay = $signed(in_tdata[27:14]);
  assign q_data.az = $signed(in_tdata[41:28]);
  assign q_data.mx = m[0];
  assign q_data.my = m[1];
  assign q_data.mz = m[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        fmin_r[i] <= '0;
        fmax_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        fmin_r[i] <= fmin_nxt[i];
        fmax_r[i] <= fmax_nxt[i];
      end
    end
  end

endmodule
`default_nettype wire

// ----- sv/tcc_fifo.sv -----
// two-entry queue between front and back end
`default_nettype none
module tcc_fifo import tcc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  item_t      push_data,
  output logic       full,
  input  wire logic  pop,
  output item_t      pop_data,
  output logic       empty
);

  item_t       mem_r [2];
  logic        wp_r, wp_nxt;
  logic        rp_r, rp_nxt;
  logic [1:0]  cnt_r, cnt_nxt;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ pop;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- sv/tcc_back.sv -----
// back end: filter, square root, shared cordic sequencer and output register
`default_nettype none
module tcc_back import tcc_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wen,
  input  wire logic [GAIN_W-1:0] cfg_wdata,
  input  wire logic              q_empty,
  input  item_t                  q_data,
  output logic                   q_pop,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [47:0]            out_tdata,
  output logic                   out_tuser
);

  localparam int         NSTEP     = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
  localparam logic [4:0] LAST_STEP = 5'(NSTEP - 1);
  localparam logic [4:0] ROOT_TOP  = 5'd29;

  state_t                   state_r, state_nxt;
  logic [1:0]               ax_r, ax_nxt;
  logic [1:0]               pass_r, pass_nxt;
  logic [4:0]               it_r, it_nxt;
  logic [GAIN_W-1:0]        gain_r, gain_nxt;
  item_t                    item_r, item_nxt;
  logic signed [S_W-1:0]    s_r [3];
  logic signed [S_W-1:0]    s_nxt [3];
  logic signed [MP_W-1:0]   prod_r, prod_nxt;
  logic [RT_W-1:0]          v_r, v_nxt, r_r, r_nxt;
  logic signed [CW-1:0]     cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [Z_W-1:0]    cz_r, cz_nxt;
  logic                     zv_r, zv_nxt;
  logic signed [Z_W-1:0]    pz_r, pz_nxt, rz_r, rz_nxt;
  logic signed [TRIG_W-1:0] cp_r, cp_nxt, sp_r, sp_nxt, cr_r, cr_nxt, sr_r, sr_nxt;
  logic signed [NUM_W-1:0]  num_r, num_nxt, u_r, u_nxt, den_r, den_nxt;
  logic                     ov_r, ov_nxt;
  logic [47:0]              od_r, od_nxt;
  logic                     oz_r, oz_nxt;

  logic [1:0]               rd_idx;
  logic signed [S_W-1:0]    s_rd;
  acc_t                     acc_sel;
  logic signed [S_W:0]      diff;
  logic signed [MA_W-1:0]   ma;
  logic signed [MB_W-1:0]   mb;
  logic signed [MP_W-1:0]   prod;
  logic signed [MP_W-1:0]   fsum;
  logic [RT_W-1:0]          bb, rb;
  logic signed [CW-1:0]     xs, ys, stx, sty, vx, vy;
  logic signed [Z_W-1:0]    at, stz;
  logic                     dir_a;
  logic                     last_step;

  assign last_step = (it_r == LAST_STEP);

  // single read port on the smoothed values
  always_comb begin
    case (state_r)
      ST_FILT_MUL, ST_FILT_ACC: rd_idx = ax_r;
      ST_SQ1:   rd_idx = (pass_r == 2'd0) ? 2'd1 : 2'd0;
      ST_SQ2:   rd_idx = 2'd2;
      ST_VLOAD: rd_idx = (pass_r == 2'd0) ? 2'd0 : 2'd1;
      default:  rd_idx = 2'd0;
    endcase
  end
  assign s_rd = s_r[rd_idx];

  always_comb begin
    case (ax_r)
      2'd0:    acc_sel = item_r.ax;
      2'd1:    acc_sel = item_r.ay;
      default: acc_sel = item_r.az;
    endcase
  end
  assign diff = (S_W+1)'($signed({acc_sel, 16'b0})) - (S_W+1)'(s_rd);

  // shared multiplier
  always_comb begin
    ma = '0;
    mb = '0;
    case (state_r)
      ST_FILT_MUL: begin
        ma = MA_W'(diff);
        mb = MB_W'($signed({1'b0, gain_r}));
      end
      ST_SQ1, ST_SQ2: begin
        ma = MA_W'(s_rd);
        mb = MB_W'(s_rd);
      end
      ST_PROD: begin
        case (it_r)
          5'd0:    begin ma = MA_W'(item_r.my); mb = MB_W'(cr_r); end
          5'd1:    begin ma = MA_W'(item_r.mz); mb = MB_W'(sr_r); end
          5'd2:    begin ma = MA_W'(item_r.my); mb = MB_W'(sr_r); end
          5'd3:    begin ma = MA_W'(item_r.mz); mb = MB_W'(cr_r); end
          5'd4:    begin ma = MA_W'(item_r.mx); mb = MB_W'(cp_r); end
          default: begin ma = MA_W'(u_r >>> 15); mb = MB_W'(sp_r >>> 15); end
        endcase
      end
      default: begin
      end
    endcase
  end
  assign prod = MP_W'(ma) * MP_W'(mb);

  assign fsum = ((prod_r + MP_W'(16384)) >>> 15) + MP_W'(s_rd);

  assign bb = RT_W'(1) << {it_r, 1'b0};
  assign rb = r_r + bb;

  // one cordic micro-rotation, vectoring or rotation
  assign xs    = cx_r >>> it_r;
  assign ys    = cy_r >>> it_r;
  assign at    = atan_q16(it_r);
  assign dir_a = (state_r == ST_VEC) ? !cy_r[CW-1] : cz_r[Z_W-1];
  assign stx   = dir_a ? (cx_r + ys) : (cx_r - ys);
  assign sty   = dir_a ? (cy_r - xs) : (cy_r + xs);
  assign stz   = dir_a ? (cz_r + at) : (cz_r - at);

  always_comb begin
    case (pass_r)
      2'd0: begin
        vy = -CW'(s_rd);
        vx = CW'($signed({1'b0, r_r[30:0]}));
      end
      2'd1: begin
        vy = CW'(s_rd);
        vx = CW'($signed({1'b0, r_r[30:0]}));
      end
      default: begin
        vy = CW'(num_r);
        vx = CW'(den_r);
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (!q_empty) state_nxt = ST_FILT_MUL;
      ST_FILT_MUL: state_nxt = ST_FILT_ACC;
      ST_FILT_ACC: state_nxt = (ax_r == 2'd2) ? ST_SQ1 : ST_FILT_MUL;
      ST_SQ1:      state_nxt = ST_SQ2;
      ST_SQ2:      state_nxt = ST_ROOT;
      ST_ROOT:     if (it_r == 5'd0) state_nxt = ST_VLOAD;
      ST_VLOAD:    state_nxt = ST_VEC;
      ST_VEC: begin
        if (last_step) begin
          case (pass_r)
            2'd0:    state_nxt = ST_SQ1;
            2'd1:    state_nxt = ST_RLOAD;
            default: state_nxt = ST_OUT;
          endcase
        end
      end
      ST_RLOAD:    state_nxt = ST_ROT;
      ST_ROT: begin
        if (last_step) state_nxt = (pass_r == 2'd0) ? ST_RLOAD : ST_PROD;
      end
      ST_PROD:     if (it_r == 5'd5) state_nxt = ST_VLOAD;
      ST_OUT:      if (!ov_r || out_tready) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    ax_nxt   = ax_r;
    pass_nxt = pass_r;
    it_nxt   = it_r;
    gain_nxt = cfg_wen ? cfg_wdata : gain_r;
    item_nxt = item_r;
    for (int i = 0; i < 3; i++) s_nxt[i] = s_r[i];
    prod_nxt = prod_r;
    v_nxt    = v_r;
    r_nxt    = r_r;
    cx_nxt   = cx_r;
    cy_nxt   = cy_r;
    cz_nxt   = cz_r;
    zv_nxt   = zv_r;
    pz_nxt   = pz_r;
    rz_nxt   = rz_r;
    cp_nxt   = cp_r;
    sp_nxt   = sp_r;
    cr_nxt   = cr_r;
    sr_nxt   = sr_r;
    num_nxt  = num_r;
    u_nxt    = u_r;
    den_nxt  = den_r;
    ov_nxt   = ov_r && !out_tready;
    od_nxt   = od_r;
    oz_nxt   = oz_r;
    q_pop    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          item_nxt = q_data;
          ax_nxt   = 2'd0;
        end
      end
      ST_FILT_MUL: prod_nxt = prod;
      ST_FILT_ACC: begin
        if (fsum > MP_W'(ACC_HI)) begin
          s_nxt[ax_r] = S_W'(ACC_HI);
        end else if (fsum < MP_W'(ACC_LO)) begin
          s_nxt[ax_r] = S_W'(ACC_LO);
        end else begin
          s_nxt[ax_r] = S_W'(fsum);
        end
        ax_nxt   = ax_r + 2'd1;
        pass_nxt = 2'd0;
      end
      ST_SQ1: prod_nxt = prod;
      ST_SQ2: begin
        v_nxt  = RT_W'(prod_r + prod);
        r_nxt  = '0;
        it_nxt = ROOT_TOP;
      end
      ST_ROOT: begin
        if (v_r >= rb) begin
          v_nxt = v_r - rb;
          r_nxt = (r_r >> 1) + bb;
        end else begin
          r_nxt = r_r >> 1;
        end
        it_nxt = it_r - 5'd1;
      end
      ST_VLOAD: begin
        it_nxt = 5'd0;
        zv_nxt = (vx == '0) && (vy == '0);
        if (vx[CW-1]) begin
          if (!vy[CW-1]) begin
            cx_nxt = vy;
            cy_nxt = -vx;
            cz_nxt = QUARTER;
          end else begin
            cx_nxt = -vy;
            cy_nxt = vx;
            cz_nxt = -QUARTER;
          end
        end else begin
          cx_nxt = vx;
          cy_nxt = vy;
          cz_nxt = '0;
        end
      end
      ST_VEC: begin
        if (!zv_r) begin
          cx_nxt = stx;
          cy_nxt = sty;
          cz_nxt = stz;
        end
        it_nxt = it_r + 5'd1;
        if (last_step) begin
          case (pass_r)
            2'd0:    pz_nxt = zv_r ? cz_r : stz;
            2'd1:    rz_nxt = zv_r ? cz_r : stz;
            default: begin
            end
          endcase
          pass_nxt = (pass_r == 2'd0) ? 2'd1 : 2'd0;
        end
      end
      ST_RLOAD: begin
        cx_nxt = START_GAIN;
        cy_nxt = '0;
        cz_nxt = (pass_r == 2'd0) ? pz_r : rz_r;
        it_nxt = 5'd0;
      end
      ST_ROT: begin
        cx_nxt = stx;
        cy_nxt = sty;
        cz_nxt = stz;
        it_nxt = it_r + 5'd1;
        if (last_step) begin
          if (pass_r == 2'd0) begin
            cp_nxt   = TRIG_W'(stx);
            sp_nxt   = TRIG_W'(sty);
            pass_nxt = 2'd1;
          end else begin
            cr_nxt   = TRIG_W'(stx);
            sr_nxt   = TRIG_W'(sty);
            pass_nxt = 2'd2;
            it_nxt   = 5'd0;
          end
        end
      end
      ST_PROD: begin
        it_nxt = it_r + 5'd1;
        case (it_r)
          5'd0:    prod_nxt = -prod;
          5'd1:    num_nxt  = NUM_W'(prod_r + prod);
          5'd2:    prod_nxt = prod;
          5'd3:    u_nxt    = NUM_W'(prod_r - prod);
          5'd4:    prod_nxt = prod;
          default: den_nxt  = NUM_W'(prod_r + prod);
        endcase
      end
      ST_OUT: begin
        if (!ov_r || out_tready) begin
          ov_nxt = 1'b1;
          od_nxt = {out_angle(cz_r), out_angle(rz_r), out_angle(pz_r)};
          oz_nxt = zv_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = oz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
      gain_r  <= GAIN_RST;
      ax_r    <= 2'd0;
      pass_r  <= 2'd0;
      it_r    <= 5'd0;
      for (int i = 0; i < 3; i++) s_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      gain_r  <= gain_nxt;
      ax_r    <= ax_nxt;
      pass_r  <= pass_nxt;
      it_r    <= it_nxt;
      for (int i = 0; i < 3; i++) s_r[i] <= s_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    prod_r <= prod_nxt;
    v_r    <= v_nxt;
    r_r    <= r_nxt;
    cx_r   <= cx_nxt;
    cy_r   <= cy_nxt;
    cz_r   <= cz_nxt;
    zv_r   <= zv_nxt;
    pz_r   <= pz_nxt;
    rz_r   <= rz_nxt;
    cp_r   <= cp_nxt;
    sp_r   <= sp_nxt;
    cr_r   <= cr_nxt;
    sr_r   <= sr_nxt;
    num_r  <= num_nxt;
    u_r    <= u_nxt;
    den_r  <= den_nxt;
    od_r   <= od_nxt;
    oz_r   <= oz_nxt;
  end

endmodule
`default_nettype wire

// ----- sv/tilt_compensated_compass.sv -----
// the back end finishes one measurement before it takes the next one from the queue; the
// work of each measurement is serialised through the one shared cordic, square-root and
// multiplier unit of the back end
// calibration words stay in the front end; a two-word queue decouples the halves
// reset: synchronous active-low rst_n clears min/max, filter state, queue and output valid,
// and loads the smoothing gain with 0.4
`default_nettype none
module tilt_compensated_compass import tcc_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wen,
  input  wire logic [GAIN_W-1:0] cfg_wdata,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [95:0]       in_tdata,   // accel_x, accel_y, accel_z, field_x, field_y, field_z
  input  wire logic [1:0]        in_tuser,   // kind
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [47:0]            out_tdata,  // pitch_deg, roll_deg, yaw_deg
  output logic                   out_tuser   // field_zero
);

  item_t q_in, q_out;
  logic  q_push, q_pop, q_full, q_empty;

  tcc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_push    (q_push),
    .q_data    (q_in),
    .q_full    (q_full)
  );

  tcc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  tcc_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .q_empty    (q_empty),
    .q_data     (q_out),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

// ----- sv/tcc_checker.sv -----
// port-level checks on the compass output channel, bound to the top level
`default_nettype none
module tcc_port_checks (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [47:0] out_tdata,
  input wire logic        out_tuser
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_zero_yaw: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[47:32] == 16'd0)
    else $error("flagged zero field with non-zero heading");

endmodule

bind tilt_compensated_compass tcc_port_checks u_tcc_port_checks (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire
